### sv/insert_coverage_expectation_core_assert.svh
// Assertion macros for the expected-coverage store.
// Depends on nothing; included by the top level, which checks its own logic.
`ifndef INSERT_COVERAGE_EXPECTATION_CORE_ASSERT_SVH
`define INSERT_COVERAGE_EXPECTATION_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define ICE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ICE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### sv/ice_pkg.sv
// Package for the expected-coverage store: sizes, codes and shared types.
// Depends on nothing; used by every module of the block.
package ice_pkg;
	localparam int MaxLen = 1024;
	localparam int AddrW = $clog2(MaxLen);
	localparam int LenW = AddrW + 1;
	localparam int SumW = 40;
	localparam int CntW = 24;
	localparam int FracW = 17;
	localparam int QuoW = SumW;
	localparam int MulW = CntW + LenW + 16;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_READ = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		CFG_REGION_LENGTH = 1'd0,
		CFG_TOTAL_COUNT = 1'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_ADD,
		ST_READ,
		ST_RDIV
	} state_t;

	// Request to the shared divider and its reply.
	typedef struct packed {
		logic start;
		logic [MulW-1:0] dividend;
		logic [CntW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [MulW-1:0] quotient;
	} div_rsp_t;
endpackage

### sv/ice_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ice_pkg; shared by the add and read paths of the sequencer.
module ice_div (
	input logic clk,
	input logic arst_n,
	input ice_pkg::div_req_t req,
	output ice_pkg::div_rsp_t rsp
);
	localparam int W = ice_pkg::MulW;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0] quo_q;
	logic [ice_pkg::CntW:0] rem_q;
	logic [ice_pkg::CntW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [ice_pkg::CntW:0] trial;

	assign trial = {rem_q[ice_pkg::CntW-1:0], quo_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= trial - {1'b0, dvs_q};
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule

### sv/ice_store.sv
// Coverage sum memory: one write port and one registered read port.
// Depends on ice_pkg for its sizes.
module ice_store (
	input logic clk,
	input logic we,
	input logic [ice_pkg::AddrW-1:0] waddr,
	input logic [ice_pkg::SumW-1:0] wdata,
	input logic [ice_pkg::AddrW-1:0] raddr,
	output logic [ice_pkg::SumW-1:0] rdata
);
	logic [ice_pkg::SumW-1:0] mem [ice_pkg::MaxLen];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### sv/insert_coverage_expectation_core.sv
// Top level of the expected-coverage store: sequencer, memory and divider.
// Depends on ice_pkg, ice_store, ice_div and the assertion macro header.
//
// Channel  | Signals                                          | Flow
// command  | start, busy, operation, fragment_length, ...     | start while busy is low
// result   | result_valid, read_position, expected_coverage, coverage_fraction | one-cycle strobe
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data        | valid and ready
//
// After reset the store is swept clear, one entry a cycle, with busy held high.
// A clear also sweeps every entry. An add visits each position of the region
// in turn, using the bit-serial divider to form each addend.
// A read holds busy while the divider runs and strobes its result in the first cycle with busy low;
// with zero total the divider is skipped and a zero sum and fraction are strobed.
// The receiver cannot stall results.
`include "insert_coverage_expectation_core_assert.svh"
module insert_coverage_expectation_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] operation,
	input logic [10:0] fragment_length,
	input logic [23:0] bin_count,
	input logic [9:0] position,
	output logic result_valid,
	output logic [9:0] read_position,
	output logic [39:0] expected_coverage,
	output logic [16:0] coverage_fraction,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [23:0] cfg_data
);
	localparam int AW = ice_pkg::AddrW;
	localparam int LW = ice_pkg::LenW;
	localparam int SW = ice_pkg::SumW;
	localparam int MW = ice_pkg::MulW;
	localparam logic [SW-1:0] SumMax = '1;

	ice_pkg::state_t state_q, state_d;
	logic [LW-1:0] len_q;
	logic [23:0] total_q;
	logic [LW-1:0] fl_q;
	logic [23:0] cnt_q;
	logic [LW-1:0] n_q;
	logic [LW-1:0] elen_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] pos_q;
	logic [1:0] ph_q;
	logic [SW-1:0] sum_q;
	logic [MW-1:0] prod_q;
	logic res_q;
	logic [SW-1:0] res_sum_q;
	logic [16:0] res_frac_q;

	logic we;
	logic [AW-1:0] waddr;
	logic [SW-1:0] wdata;
	logic [AW-1:0] raddr;
	logic [SW-1:0] rdata;
	ice_pkg::div_req_t dreq;
	ice_pkg::div_rsp_t drsp;

	logic [LW-1:0] elen;
	logic [LW-1:0] k1;
	logic [LW-1:0] rk;
	logic [LW-1:0] m_a;
	logic [LW-1:0] m_b;
	logic [LW-1:0] m;
	logic [SW:0] add_sum;

	ice_store u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	ice_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign elen = (len_q == '0) ? LW'(1) :
		(len_q > LW'(ice_pkg::MaxLen)) ? LW'(ice_pkg::MaxLen) : len_q;
	assign k1 = LW'(idx_q) + LW'(1);
	assign rk = elen_q - LW'(idx_q);
	assign m_a = (k1 < fl_q) ? k1 : fl_q;
	assign m_b = (n_q < rk) ? n_q : rk;
	assign m = (m_a < m_b) ? m_a : m_b;
	assign add_sum = {1'b0, sum_q} + {1'b0, drsp.quotient[SW-1:0]};

	assign busy = (state_q != ice_pkg::ST_IDLE);
	assign cfg_ready = (state_q == ice_pkg::ST_IDLE) && !start;
	assign raddr = (state_q == ice_pkg::ST_IDLE) ? position : idx_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ice_pkg::ST_IDLE: begin
				if (start) begin
					case (operation)
						ice_pkg::OP_ADD: begin
							if (fragment_length != '0 && bin_count != '0 &&
								fragment_length <= elen) begin
								state_d = ice_pkg::ST_ADD;
							end
						end
						ice_pkg::OP_READ: state_d = ice_pkg::ST_READ;
						ice_pkg::OP_CLEAR: state_d = ice_pkg::ST_CLEAR;
						default: state_d = ice_pkg::ST_IDLE;
					endcase
				end
			end
			ice_pkg::ST_CLEAR: begin
				if (idx_q == '1) begin
					state_d = ice_pkg::ST_IDLE;
				end
			end
			ice_pkg::ST_ADD: begin
				if (ph_q == 2'd3 && drsp.done && k1 == elen_q) begin
					state_d = ice_pkg::ST_IDLE;
				end
			end
			ice_pkg::ST_READ: begin
				if (total_q == '0) begin
					state_d = ice_pkg::ST_IDLE;
				end else begin
					state_d = ice_pkg::ST_RDIV;
				end
			end
			ice_pkg::ST_RDIV: begin
				if (drsp.done) begin
					state_d = ice_pkg::ST_IDLE;
				end
			end
			default: state_d = ice_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = '0;
		dreq.start = 1'b0;
		dreq.dividend = prod_q;
		dreq.divisor = 24'(n_q);
		case (state_q)
			ice_pkg::ST_CLEAR: we = 1'b1;
			ice_pkg::ST_ADD: begin
				dreq.start = (ph_q == 2'd2);
				if (ph_q == 2'd3 && drsp.done) begin
					we = 1'b1;
					wdata = (add_sum[SW] || drsp.quotient[MW-1:SW] != '0) ?
						SumMax : add_sum[SW-1:0];
				end
			end
			ice_pkg::ST_READ: begin
				dreq.start = (total_q != '0);
				dreq.dividend = MW'(rdata);
				dreq.divisor = total_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ice_pkg::ST_CLEAR;
			idx_q <= '0;
			ph_q <= '0;
			res_q <= 1'b0;
			len_q <= LW'(ice_pkg::MaxLen);
			total_q <= '0;
		end else begin
			state_q <= state_d;
			res_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ice_pkg::CFG_REGION_LENGTH: len_q <= cfg_data[LW-1:0];
					ice_pkg::CFG_TOTAL_COUNT: total_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ice_pkg::ST_IDLE: begin
					idx_q <= '0;
					ph_q <= '0;
					if (start && operation == ice_pkg::OP_READ) begin
						idx_q <= position;
					end
				end
				ice_pkg::ST_CLEAR: idx_q <= idx_q + 1'b1;
				ice_pkg::ST_ADD: begin
					// Phases: read issued, multiply, divide start, wait and write.
					if (ph_q != 2'd3) begin
						ph_q <= ph_q + 1'b1;
					end else if (drsp.done) begin
						ph_q <= '0;
						idx_q <= idx_q + 1'b1;
					end
				end
				ice_pkg::ST_READ: begin
					if (total_q == '0) begin
						res_q <= 1'b1;
					end
				end
				ice_pkg::ST_RDIV: begin
					if (drsp.done) begin
						res_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ice_pkg::ST_IDLE && start) begin
			fl_q <= fragment_length;
			cnt_q <= bin_count;
			n_q <= elen - fragment_length + LW'(1);
			elen_q <= elen;
			pos_q <= position;
		end
		if (state_q == ice_pkg::ST_ADD && ph_q == 2'd1) begin
			sum_q <= rdata;
		end
		if (state_q == ice_pkg::ST_ADD && ph_q == 2'd1) begin
			prod_q <= {MW'(cnt_q) * MW'(m)} << 16;
		end
		if (state_q == ice_pkg::ST_READ) begin
			res_sum_q <= (total_q == '0) ? '0 : rdata;
			res_frac_q <= '0;
		end
		if (state_q == ice_pkg::ST_RDIV && drsp.done) begin
			res_frac_q <= (drsp.quotient > MW'(65536)) ? 17'd65536 :
				drsp.quotient[16:0];
		end
	end

	assign result_valid = res_q;
	assign read_position = pos_q;
	assign expected_coverage = res_sum_q;
	assign coverage_fraction = res_frac_q;

	`ICE_ASSERT_IMP(a_cfg_idle, clk, arst_n, cfg_ready, state_q == ice_pkg::ST_IDLE)
	`ICE_ASSERT_IMP(a_res_idle, clk, arst_n, result_valid, !busy)
	`ICE_ASSERT_IMP(a_div_free, clk, arst_n, dreq.start, !drsp.busy)
	`ICE_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy && operation == ice_pkg::OP_CLEAR, busy)
endmodule

### tb/sv/tb_insert_coverage_expectation_core.sv
// Testbench for insert_coverage_expectation_core: random and directed add, read and clear
// commands, register writes between phases, results checked against a local coverage store.
// Depends on ice_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_insert_coverage_expectation_core;
	import ice_pkg::*;

	localparam int CycleLimit = 6000000;
	localparam int SettleCycles = 8;

	typedef enum logic [1:0] {
		K_CMD,
		K_REG,
		K_DRAIN
	} plan_kind_t;

	typedef struct {
		plan_kind_t kind;
		bit steady;
		op_t op;
		logic [10:0] frag;
		logic [23:0] cnt;
		logic [9:0] pos;
		cfg_idx_t idx;
		logic [23:0] data;
	} plan_t;

	typedef struct {
		logic [9:0] pos;
		logic [39:0] sum;
		logic [16:0] frac;
	} coverage_t;

	logic clk, arst_n, start, busy, result_valid, cfg_valid, cfg_ready;
	logic [1:0] operation;
	logic [10:0] fragment_length;
	logic [23:0] bin_count, cfg_data;
	logic [9:0] position, read_position;
	logic [39:0] expected_coverage;
	logic [16:0] coverage_fraction;
	logic [0:0] cfg_index;

	plan_t cmd_plan[$];
	coverage_t coverage_due[$];
	logic [39:0] model_sum[MaxLen];
	logic [10:0] model_len;
	logic [23:0] model_total;
	logic cmd_taken, reg_taken;
	int settle, fails, cycles;

	insert_coverage_expectation_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .fragment_length(fragment_length),
		.bin_count(bin_count), .position(position),
		.result_valid(result_valid), .read_position(read_position),
		.expected_coverage(expected_coverage), .coverage_fraction(coverage_fraction),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic add_bin(input logic [10:0] fl, input logic [23:0] cnt);
		longint unsigned len, n, m, inc, s;
		len = model_len;
		if (len == 0) len = 1;
		if (len > MaxLen) len = MaxLen;
		if (fl == 0 || cnt == 0 || fl > len) return;
		n = len - fl + 1;
		for (longint unsigned k = 1; k <= len; k++) begin
			m = k;
			if (fl < m) m = fl;
			if (n < m) m = n;
			if (len - k + 1 < m) m = len - k + 1;
			inc = (longint'(cnt) * m * 65536) / n;
			s = model_sum[k - 1] + inc;
			model_sum[k - 1] = (s > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : s[39:0];
		end
	endtask

	function automatic coverage_t read_coverage(input logic [9:0] pos);
		coverage_t c;
		longint unsigned q;
		c.pos = pos;
		c.sum = '0;
		c.frac = '0;
		if (model_total != 0) begin
			c.sum = model_sum[pos];
			q = c.sum / model_total;
			c.frac = (q > 65536) ? 17'd65536 : q[16:0];
		end
		return c;
	endfunction

	// Predictor and result check, both on the rising edge.
	always @(posedge clk) begin
		coverage_t c;
		cmd_taken <= arst_n && start && !busy;
		reg_taken <= arst_n && cfg_valid && cfg_ready;
		if (arst_n && start && !busy) begin
			case (op_t'(operation))
				OP_ADD: add_bin(fragment_length, bin_count);
				OP_READ: coverage_due.push_back(read_coverage(position));
				OP_CLEAR: foreach (model_sum[i]) model_sum[i] = '0;
				default: ;
			endcase
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_idx_t'(cfg_index) == CFG_REGION_LENGTH) model_len = cfg_data[10:0];
			else model_total = cfg_data;
		end
		if (arst_n && result_valid) begin
			if (coverage_due.size() == 0) begin
				$error("result with no read outstanding, position %0d", read_position);
				fails++;
			end else begin
				c = coverage_due.pop_front();
				if (read_position !== c.pos) begin
					$error("read_position: expected %0d, got %0d", c.pos, read_position);
					fails++;
				end
				if (expected_coverage !== c.sum) begin
					$error("expected_coverage: expected %0d, got %0d", c.sum,
						expected_coverage);
					fails++;
				end
				if (coverage_fraction !== c.frac) begin
					$error("coverage_fraction: expected %0d, got %0d", c.frac,
						coverage_fraction);
					fails++;
				end
			end
		end
	end

	// Driver: one transfer in flight at a time, on the command or register channel.
	always @(negedge clk) begin
		logic nxt_start, nxt_cfg;
		plan_t e;
		if (!arst_n) begin
			settle <= 0;
		end else begin
			nxt_start = start;
			nxt_cfg = cfg_valid;
			if (start && cmd_taken) nxt_start = 1'b0;
			if (cfg_valid && reg_taken) nxt_cfg = 1'b0;
			settle <= (busy || start) ? 0 : settle + 1;
			if (!nxt_start && !nxt_cfg && cmd_plan.size() > 0) begin
				e = cmd_plan[0];
				case (e.kind)
					K_CMD: if (e.steady || $urandom_range(99) >= 20) begin
						operation <= e.op;
						fragment_length <= e.frag;
						bin_count <= e.cnt;
						position <= e.pos;
						nxt_start = 1'b1;
						void'(cmd_plan.pop_front());
					end
					K_REG: if (coverage_due.size() == 0 && !busy && !start
							&& settle >= SettleCycles && $urandom_range(99) >= 20) begin
						cfg_index <= e.idx;
						cfg_data <= e.data;
						nxt_cfg = 1'b1;
						void'(cmd_plan.pop_front());
					end
					default: if (coverage_due.size() == 0 && !busy && !start)
						void'(cmd_plan.pop_front());
				endcase
			end
			start <= nxt_start;
			cfg_valid <= nxt_cfg;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic void push_cmd(op_t op, logic [10:0] fl, logic [23:0] cnt,
			logic [9:0] pos, bit steady = 0);
		plan_t e;
		e.kind = K_CMD;
		e.steady = steady;
		e.op = op;
		e.frag = fl;
		e.cnt = cnt;
		e.pos = pos;
		cmd_plan.push_back(e);
	endfunction

	function automatic void push_reg(cfg_idx_t idx, logic [23:0] data);
		plan_t e;
		e.kind = K_REG;
		e.idx = idx;
		e.data = data;
		cmd_plan.push_back(e);
	endfunction

	function automatic void push_drain();
		plan_t e;
		e.kind = K_DRAIN;
		cmd_plan.push_back(e);
	endfunction

	function automatic logic [23:0] pick_count();
		case ($urandom_range(4))
			0: return 24'hFF_FFFF;
			1: return 24'($urandom_range(3));
			2: return 24'($urandom_range(1000));
			default: return 24'($urandom);
		endcase
	endfunction

	initial begin
		int n_items, len, phase_items;
		bit steady;
		start = 1'b0;
		cfg_valid = 1'b0;
		operation = OP_NONE;
		fragment_length = '0;
		bin_count = '0;
		position = '0;
		cfg_index = CFG_REGION_LENGTH;
		cfg_data = '0;
		cmd_taken = 1'b0;
		reg_taken = 1'b0;
		fails = 0;
		cycles = 0;
		settle = 0;
		model_len = 11'd1024;
		model_total = '0;
		foreach (model_sum[i]) model_sum[i] = '0;
		arst_n = 1'b0;

		// Directed part: field extremes, every operation, the ignored cases.
		push_reg(CFG_REGION_LENGTH, 24'd8);
		push_reg(CFG_TOTAL_COUNT, 24'd1000);
		push_cmd(OP_ADD, 11'd1, 24'hFF_FFFF, '0);
		push_cmd(OP_ADD, 11'd8, 24'd5, '0);
		push_cmd(OP_ADD, 11'd3, 24'd777, '0);
		push_cmd(OP_ADD, 11'd9, 24'd50, '0);
		push_cmd(OP_ADD, 11'd2047, 24'd50, '0);
		push_cmd(OP_ADD, 11'd0, 24'd50, '0);
		push_cmd(OP_ADD, 11'd4, 24'd0, '0);
		for (int p = 0; p < 8; p += 3) push_cmd(OP_READ, '0, '0, 10'(p));
		push_cmd(OP_READ, 11'd0, 24'd0, 10'd1023);
		push_cmd(OP_NONE, 11'd2, 24'd9, 10'd1);
		push_cmd(OP_READ, '0, '0, 10'd1);
		push_cmd(OP_CLEAR, '0, '0, '0);
		push_cmd(OP_READ, '0, '0, 10'd2);
		push_reg(CFG_TOTAL_COUNT, 24'd0);
		push_reg(CFG_REGION_LENGTH, 24'd0);
		push_cmd(OP_ADD, 11'd1, 24'hFF_FFFF, '0);
		push_cmd(OP_ADD, 11'd1, 24'hFF_FFFF, '0);
		push_cmd(OP_READ, '0, '0, '0);
		push_reg(CFG_TOTAL_COUNT, 24'hFF_FFFF);
		push_cmd(OP_READ, '0, '0, '0);
		push_reg(CFG_REGION_LENGTH, 24'd2047);
		push_reg(CFG_TOTAL_COUNT, 24'd1);
		push_cmd(OP_ADD, 11'd1024, 24'hFF_FFFF, '0);
		push_cmd(OP_READ, '0, '0, 10'd1023);
		push_cmd(OP_CLEAR, '0, '0, '0);
		n_items = 22;

		// Random phases, mostly short regions so that adds stay quick.
		while (n_items < 568) begin
			len = ($urandom_range(49) == 0) ? 1024 : $urandom_range(1, 24);
			push_reg(CFG_REGION_LENGTH, ($urandom_range(9) == 0) ? 24'd0 : 24'(len));
			case ($urandom_range(5))
				0: push_reg(CFG_TOTAL_COUNT, 24'd0);
				1: push_reg(CFG_TOTAL_COUNT, 24'd1);
				2: push_reg(CFG_TOTAL_COUNT, 24'hFF_FFFF);
				3: push_reg(CFG_TOTAL_COUNT, 24'($urandom_range(1, 100)));
				default: push_reg(CFG_TOTAL_COUNT, 24'($urandom));
			endcase
			phase_items = $urandom_range(15, 35);
			for (int i = 0; i < phase_items; i++) begin
				steady = (n_items >= 250 && n_items < 350);
				case ($urandom_range(19))
					0: push_cmd(OP_CLEAR, 11'($urandom), 24'($urandom), 10'($urandom),
						steady);
					1: push_cmd(OP_NONE, 11'($urandom), 24'($urandom), 10'($urandom),
						steady);
					2, 3, 4, 5, 6, 7: begin
						if (len == 1024 && i > 0)
							push_cmd(OP_READ, '0, '0, 10'($urandom), steady);
						else if ($urandom_range(7) == 0)
							push_cmd(OP_ADD, 11'($urandom), pick_count(), 10'($urandom),
								steady);
						else
							push_cmd(OP_ADD, 11'($urandom_range(len + 1)), pick_count(),
								10'($urandom), steady);
					end
					default: begin
						if ($urandom_range(5) == 0)
							push_cmd(OP_READ, 11'($urandom), 24'($urandom), 10'($urandom),
								steady);
						else
							push_cmd(OP_READ, 11'($urandom), 24'($urandom),
								10'($urandom_range(len - 1)), steady);
					end
				endcase
				n_items++;
				if ($urandom_range(29) == 0) push_drain();
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (cmd_plan.size() == 0);
		@(posedge clk);
		while (start || cfg_valid || busy || coverage_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fails == 0 && coverage_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
